FILE: src/zcps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Zero-crossing profile sequencer package
// Shared word types, command codes and sizes for the sequencer and its cells.
// ----------------------------------------------------------------------------
package zcps_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int CHANNELS_DEF = 8;
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
  localparam int MASK_W       = 8;
  localparam int PROFILE_W    = 64;
  localparam int POS_W        = $clog2(PROFILE_W);

  localparam logic [POS_W-1:0] LAST_BIT = POS_W'(PROFILE_W - 1);

  localparam logic [2:0] OP_REGISTER = 3'd0;
  localparam logic [2:0] OP_ENABLE   = 3'd1;
  localparam logic [2:0] OP_DISABLE  = 3'd2;
  localparam logic [2:0] OP_TICK     = 3'd3;
  localparam logic [2:0] OP_CHECK    = 3'd4;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [7:0]           pin;
    logic [7:0]           load_id;
    logic [PROFILE_W-1:0] profile_bits;
    logic                 repeat_req;
    logic                 zc_positive;
  } in_word_t;

  typedef struct packed {
    logic [MASK_W-1:0] drive_mask;
    logic [MASK_W-1:0] active_mask;
    logic              status;
    logic [3:0]        channel_count;
  } out_word_t;

  typedef struct packed {
    logic             valid;
    in_word_t         cmd;
    logic [CNT_W-1:0] count;
    logic             found;
    logic             err;
  } wave_t;

  typedef struct packed {
    logic level;
    logic enabled;
  } cell_stat_t;

endpackage
`default_nettype wire

FILE: src/zcps_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Zero-crossing profile sequencer cell
// Holds one channel and applies the command word as it passes down the row.
// ----------------------------------------------------------------------------
module zcps_cell
  import zcps_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire wave_t wave_in,
  output wave_t      wave_out,
  output cell_stat_t stat
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [7:0]           pin_r, pin_nxt;
  logic [7:0]           load_r, load_nxt;
  logic                 en_r, en_nxt;
  logic                 rep_r, rep_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [PROFILE_W-1:0] cur_r, cur_nxt;
  logic [PROFILE_W-1:0] q_r, q_nxt;
  logic                 qv_r, qv_nxt;
  logic                 lvl_r, lvl_nxt;
  wave_t                wave_r, wave_nxt;

  logic live;
  logic hit;
  logic bit_now;

  assign live    = wave_in.valid && (MY_IDX < wave_in.count);
  assign hit     = live && (pin_r == wave_in.cmd.pin) && !wave_in.found;
  assign bit_now = cur_r[pos_r];

  always_comb begin
    pin_nxt  = pin_r;
    load_nxt = load_r;
    en_nxt   = en_r;
    rep_nxt  = rep_r;
    pos_nxt  = pos_r;
    cur_nxt  = cur_r;
    q_nxt    = q_r;
    qv_nxt   = qv_r;
    lvl_nxt  = lvl_r;
    wave_nxt = wave_in;
    if (wave_in.valid) begin
      unique case (wave_in.cmd.opcode)
        OP_REGISTER: begin
          if (wave_in.count == MY_IDX) begin
            pin_nxt  = wave_in.cmd.pin;
            load_nxt = wave_in.cmd.load_id;
          end
        end
        OP_ENABLE: begin
          if (hit) begin
            wave_nxt.found = 1'b1;
            if (en_r) begin
              q_nxt  = wave_in.cmd.profile_bits;
              qv_nxt = 1'b1;
            end else begin
              cur_nxt = wave_in.cmd.profile_bits;
              pos_nxt = '0;
              rep_nxt = rep_r | wave_in.cmd.repeat_req;
              en_nxt  = 1'b1;
            end
          end
        end
        OP_DISABLE: begin
          if (hit) begin
            wave_nxt.found = 1'b1;
            en_nxt  = 1'b0;
            rep_nxt = 1'b0;
            pos_nxt = '0;
            cur_nxt = '0;
            q_nxt   = '0;
            qv_nxt  = 1'b0;
            lvl_nxt = 1'b0;
          end
        end
        OP_TICK: begin
          if (live && en_r && !(pos_r == '0 && !wave_in.cmd.zc_positive)) begin
            lvl_nxt = bit_now;
            if (pos_r == LAST_BIT) begin
              pos_nxt = '0;
              if (qv_r) begin
                cur_nxt = q_r;
                qv_nxt  = 1'b0;
              end else if (!rep_r) begin
                en_nxt  = 1'b0;
                cur_nxt = '0;
                q_nxt   = '0;
                lvl_nxt = 1'b0;
              end
            end else begin
              pos_nxt = pos_r + POS_W'(1);
            end
          end
        end
        OP_CHECK: begin
          if (live && en_r && !bit_now) begin
            lvl_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pin_r  <= pin_nxt;
    load_r <= load_nxt;
    cur_r  <= cur_nxt;
    q_r    <= q_nxt;
    if (!rst_n) begin
      en_r   <= 1'b0;
      rep_r  <= 1'b0;
      pos_r  <= '0;
      qv_r   <= 1'b0;
      lvl_r  <= 1'b0;
      wave_r <= '0;
    end else begin
      en_r   <= en_nxt;
      rep_r  <= rep_nxt;
      pos_r  <= pos_nxt;
      qv_r   <= qv_nxt;
      lvl_r  <= lvl_nxt;
      wave_r <= wave_nxt;
    end
  end

  assign wave_out     = wave_r;
  assign stat.level   = lvl_r;
  assign stat.enabled = en_r;

  // The load id is stored for the channel and has no reader in this block.
  logic unused_load;
  assign unused_load = ^load_r;

`ifndef SYNTH
  a_qv_needs_en: assert property (@(posedge clk) disable iff (!rst_n)
    qv_r |-> en_r) else $error("queued profile on a disabled channel");
  a_lvl_needs_en: assert property (@(posedge clk) disable iff (!rst_n)
    !en_r && !$past(en_r) && !$past(lvl_r) |-> !lvl_r)
    else $error("idle channel drove its pin on");
  a_found_once: assert property (@(posedge clk) disable iff (!rst_n)
    wave_in.valid && wave_in.found |=> wave_r.found)
    else $error("match flag lost in the row");
`endif

endmodule
`default_nettype wire

FILE: src/zero_cross_profile_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Zero-crossing profile sequencer
// Drives up to CHANNELS load pins from 64-bit profiles in step with the grid.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. It then walks
// down a row of CHANNELS channel cells, one cell per cycle, and each cell
// applies it to its own channel. The result word appears on out_data with
// out_valid high for one cycle, registered as the word leaves the last cell;
// busy drops in that same cycle, so the next word can be taken at the end of
// it, and no new word is taken while one is in the row. The result must be
// captured in the strobe cycle.
module zero_cross_profile_sequencer
  import zcps_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  output logic          busy,
  input  wire in_word_t in_data,
  output logic          out_valid,
  output out_word_t     out_data
);

  localparam logic [CNT_W-1:0] CH_CNT = CNT_W'(CHANNELS);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  wave_t            head_r, head_nxt;
  logic             out_valid_r;
  out_word_t        out_r, out_nxt;

  wave_t      wave [CHANNELS+1];
  cell_stat_t stat [CHANNELS];
  logic [MASK_W-1:0] drive_m, active_m;
  logic accept;
  wave_t tail;

  assign accept  = start && !busy_r;
  assign wave[0] = head_r;
  assign tail    = wave[CHANNELS];

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    zcps_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wave_in (wave[g]),
      .wave_out(wave[g+1]),
      .stat    (stat[g])
    );
  end

  for (genvar m = 0; m < MASK_W; m++) begin : g_mask
    if (m < CHANNELS) begin : g_on
      assign drive_m[m]  = stat[m].level;
      assign active_m[m] = stat[m].enabled;
    end else begin : g_off
      assign drive_m[m]  = 1'b0;
      assign active_m[m] = 1'b0;
    end
  end

  always_comb begin
    count_nxt      = count_r;
    head_nxt       = head_r;
    head_nxt.valid = 1'b0;
    busy_nxt       = busy_r;
    if (accept) begin
      busy_nxt       = 1'b1;
      head_nxt.valid = 1'b1;
      head_nxt.cmd   = in_data;
      head_nxt.count = count_r;
      head_nxt.found = 1'b0;
      head_nxt.err   = (in_data.opcode == OP_REGISTER) && (count_r >= CH_CNT);
      if (in_data.opcode == OP_REGISTER && count_r < CH_CNT) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (tail.valid) begin
      busy_nxt = 1'b0;
    end
    out_nxt.drive_mask    = drive_m;
    out_nxt.active_mask   = active_m;
    out_nxt.channel_count = count_r[3:0];
    priority if (tail.cmd.opcode == OP_REGISTER) begin
      out_nxt.status = tail.err;
    end else if (tail.cmd.opcode == OP_ENABLE || tail.cmd.opcode == OP_DISABLE) begin
      out_nxt.status = !tail.found;
    end else begin
      out_nxt.status = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= tail.valid;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CH_CNT) else $error("channel count above table size");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r |=> busy_r && head_r.valid) else $error("word taken but not started");
  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> busy_r) else $error("word left the row while idle");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r) else $error("result shown while still busy");
`endif

endmodule
`default_nettype wire

FILE: bench/zero_cross_profile_sequencer_tb.sv
// ----------------------------------------------------------------------------
// Zero-crossing profile sequencer testbench
// Sends command words with random gaps and checks every result word against
// a cycle-free model of the channel table, profiles, queues and pin levels.
// ----------------------------------------------------------------------------
module zero_cross_profile_sequencer_tb;
  import zcps_pkg::*;

  localparam int NCH            = 8;
  localparam int RANDOM_WORDS   = 500;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  class profile_tracker;
    logic [7:0]  pin_of      [NCH];
    logic [7:0]  load_of     [NCH];
    int          count;
    bit          enabled     [NCH];
    bit          repeating   [NCH];
    logic [5:0]  position    [NCH];
    logic [63:0] profile     [NCH];
    logic [63:0] next_profile[NCH];
    bit          next_valid  [NCH];
    bit          level       [NCH];
    out_word_t   expected_words[$];
    int unsigned failures;

    function new();
      count = 0;
      failures = 0;
      for (int i = 0; i < NCH; i++) begin
        pin_of[i] = '0;
        load_of[i] = '0;
        drop_channel(i);
      end
    endfunction

    function void drop_channel(int i);
      enabled[i] = 0;
      repeating[i] = 0;
      position[i] = '0;
      profile[i] = '0;
      next_profile[i] = '0;
      next_valid[i] = 0;
      level[i] = 0;
    endfunction

    function int find_channel(logic [7:0] pin);
      for (int i = 0; i < count; i++)
        if (pin_of[i] == pin) return i;
      return -1;
    endfunction

    function void apply_command(in_word_t w);
      out_word_t r;
      int ch;
      r = '0;
      case (w.opcode)
        OP_REGISTER: begin
          if (count < NCH) begin
            pin_of[count] = w.pin;
            load_of[count] = w.load_id;
            count++;
          end else begin
            r.status = 1'b1;
          end
        end
        OP_ENABLE: begin
          ch = find_channel(w.pin);
          if (ch < 0) begin
            r.status = 1'b1;
          end else if (enabled[ch]) begin
            next_profile[ch] = w.profile_bits;
            next_valid[ch] = 1;
          end else begin
            profile[ch] = w.profile_bits;
            position[ch] = '0;
            if (w.repeat_req) repeating[ch] = 1;
            enabled[ch] = 1;
          end
        end
        OP_DISABLE: begin
          ch = find_channel(w.pin);
          if (ch < 0) r.status = 1'b1;
          else drop_channel(ch);
        end
        OP_TICK: begin
          for (int i = 0; i < count; i++) begin
            if (!enabled[i] || (position[i] == 0 && !w.zc_positive)) continue;
            level[i] = profile[i][position[i]];
            if (position[i] == LAST_BIT) begin
              position[i] = '0;
              if (next_valid[i]) begin
                profile[i] = next_profile[i];
                next_valid[i] = 0;
              end else if (!repeating[i]) begin
                drop_channel(i);
              end
            end else begin
              position[i]++;
            end
          end
        end
        OP_CHECK: begin
          for (int i = 0; i < count; i++)
            if (enabled[i] && !profile[i][position[i]]) level[i] = 0;
        end
        default: begin
        end
      endcase
      for (int i = 0; i < NCH && i < MASK_W; i++) begin
        r.drive_mask[i] = level[i];
        r.active_mask[i] = enabled[i];
      end
      r.channel_count = 4'(count);
      expected_words.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s expected %0h actual %0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word with no command pending: %0h", got);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      compare("drive_mask", want.drive_mask, got.drive_mask);
      compare("active_mask", want.active_mask, got.active_mask);
      compare("status", 8'(want.status), 8'(got.status));
      compare("channel_count", 8'(want.channel_count), 8'(got.channel_count));
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_data = '0;
  logic      out_valid;
  out_word_t out_data;

  profile_tracker tracker;
  bit             burst = 0;
  int             idle_cycles = 0;

  zero_cross_profile_sequencer #(.CHANNELS(NCH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue(input logic [2:0] op, input logic [7:0] pin, input logic [7:0] load,
                       input logic [63:0] bits, input logic rep, input logic zc);
    in_word_t w;
    int gap;
    w.opcode = op;
    w.pin = pin;
    w.load_id = load;
    w.profile_bits = bits;
    w.repeat_req = rep;
    w.zc_positive = zc;
    if ($urandom_range(0, 39) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.apply_command(w);
  endtask

  function automatic logic [63:0] random_profile();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [7:0] pins [NCH];
    logic [7:0] pick;
    int roll;
    pins = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'hC3, 8'h3C, 8'h5A, 8'h81};
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(OP_TICK, 8'h00, 8'h00, '0, 1'b0, 1'b1);
    issue(OP_CHECK, 8'h00, 8'h00, '0, 1'b0, 1'b0);
    issue(OP_ENABLE, 8'h00, 8'h00, '1, 1'b1, 1'b0);
    issue(OP_DISABLE, 8'hFF, 8'hFF, '0, 1'b0, 1'b0);
    for (int i = 0; i < NCH; i++)
      issue(OP_REGISTER, pins[i], (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
            '0, 1'b0, 1'b0);
    issue(OP_REGISTER, 8'h77, 8'h11, '0, 1'b0, 1'b0);
    issue(OP_ENABLE, 8'h00, 8'h00, '1, 1'b0, 1'b0);
    issue(OP_ENABLE, 8'hFF, 8'h00, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0);
    issue(OP_ENABLE, 8'h5A, 8'h00, '0, 1'b0, 1'b0);
    issue(OP_ENABLE, 8'h00, 8'h00, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
    issue(OP_TICK, 8'h00, 8'h00, '0, 1'b0, 1'b0);
    issue(OP_TICK, 8'h00, 8'h00, '0, 1'b0, 1'b1);
    issue(OP_TICK, 8'h00, 8'h00, '0, 1'b0, 1'b0);
    issue(OP_CHECK, 8'h00, 8'h00, '0, 1'b0, 1'b0);
    issue(OP_DISABLE, 8'hFF, 8'h00, '0, 1'b0, 1'b0);
    for (logic [3:0] op = {1'b0, OP_UNUSED_LO}; op <= {1'b0, OP_UNUSED_HI}; op++)
      issue(op[2:0], 8'($urandom), 8'($urandom), {$urandom, $urandom}, 1'b1, 1'b1);
    issue(OP_ENABLE, 8'h77, 8'h00, '1, 1'b0, 1'b0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      roll = $urandom_range(0, 99);
      pick = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pins[$urandom_range(0, NCH - 1)];
      if (roll < 50)
        issue(OP_TICK, 8'($urandom), 8'($urandom), {$urandom, $urandom},
              1'($urandom), 1'($urandom_range(0, 2) != 0));
      else if (roll < 70)
        issue(OP_ENABLE, pick, 8'($urandom), random_profile(), 1'($urandom), 1'($urandom));
      else if (roll < 73)
        issue(OP_DISABLE, pick, 8'($urandom), {$urandom, $urandom}, 1'($urandom),
              1'($urandom));
      else if (roll < 90)
        issue(OP_CHECK, 8'($urandom), 8'($urandom), {$urandom, $urandom}, 1'($urandom),
              1'($urandom));
      else if (roll < 95)
        issue(OP_REGISTER, 8'($urandom), 8'($urandom), {$urandom, $urandom}, 1'($urandom),
              1'($urandom));
      else
        issue(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 8'($urandom), 8'($urandom),
              {$urandom, $urandom}, 1'($urandom), 1'($urandom));
    end
    start <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (2 * (NCH + 1)) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
